@@ sv/servo_velocity_step_unit_assert.svh @@
// Assertion helpers for the servo velocity step unit.
// Both expect clk and arst_n in the scope where they are used.
`ifndef SERVO_VELOCITY_STEP_UNIT_ASSERT_SVH
`define SERVO_VELOCITY_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define SVS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svs: same-cycle check failed");

// next-cycle implication
`define SVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svs: next-cycle check failed");

`endif

@@ sv/svs_pkg.sv @@
package svs_pkg;

	// default position width and queue depth
	localparam int POS_WIDTH_DEF   = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// register and field widths
	localparam int THR_W    = 23;
	localparam int GAIN_W   = 5;
	localparam int MS_W     = 23;
	localparam int THR_SQ_W = 2 * THR_W;
	localparam int VEL_W    = 24;

	// quotient bits per gain divider stage
	localparam int GDIG = 4;

	// velocity saturation limits (magnitudes)
	localparam int VEL_POS_MAG = 2 ** (VEL_W - 1) - 1;
	localparam int VEL_NEG_MAG = 2 ** (VEL_W - 1);

	// register reset values
	localparam logic [THR_W-1:0]    THR_RST    = THR_W'(328);
	localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(2);
	localparam logic [MS_W-1:0]     MS_RST     = MS_W'(328);
	localparam logic [THR_SQ_W-1:0] THR_SQ_RST = THR_SQ_W'(328 * 328);

	// APB register map
	localparam int ADDR_W    = 4;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_THR  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_GAIN = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_MS   = REG_IDX_W'(2);

	// live configuration seen by the datapath
	typedef struct packed {
		logic [THR_W-1:0]    thr;
		logic [THR_SQ_W-1:0] thr_sq;
		logic [GAIN_W-1:0]   gain;
		logic [MS_W-1:0]     spd_floor;
	} svs_cfg_t;

	// queue status toward both sides
	typedef struct packed {
		logic full;
		logic empty;
	} svs_q_stat_t;

endpackage

@@ sv/svs_if.sv @@
// position sample channel
interface svs_in_if import svs_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] target_x;
	logic signed [POS_WIDTH-1:0] target_y;
	logic signed [POS_WIDTH-1:0] target_z;
	logic signed [POS_WIDTH-1:0] current_x;
	logic signed [POS_WIDTH-1:0] current_y;
	logic signed [POS_WIDTH-1:0] current_z;

	modport source (
		output valid, target_x, target_y, target_z, current_x, current_y, current_z,
		input  ready
	);
	modport sink (
		input  valid, target_x, target_y, target_z, current_x, current_y, current_z,
		output ready
	);
endinterface

// velocity command channel
interface svs_out_if import svs_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic                    arrived;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;
	logic signed [VEL_W-1:0] vel_z;

	modport source (
		output valid, arrived, vel_x, vel_y, vel_z,
		input  ready
	);
	modport sink (
		input  valid, arrived, vel_x, vel_y, vel_z,
		output ready
	);
endinterface

@@ sv/servo_velocity_step_unit.sv @@
// Servo velocity step unit.
// sample: one word per position pair (target and measured x, y, z, signed
//   Q16); taken when sample.valid and sample.ready are both high.
// cmd: one word per sample: arrived flag and velocity x, y, z (signed Q16);
//   handed over when cmd.valid and cmd.ready are both high.
// APB port: arrive threshold at 0x0, gain divisor at 0x4, min speed at 0x8.
//   Write only while no word is in flight.
// Throughput: one word per cycle, sustained while cmd.ready stays high.
// Path from acceptance to cmd.valid: the three front stages, the queue,
//   the 4-bit-per-stage gain divider, the max and product stages, the
//   23-stage min-speed scaling divider and the output register.
// Stall: the front (three stages) fills a four-word queue; the back pipeline
//   freezes while a result waits in the output register. sample.ready drops
//   only when the queue is full and the front's last stage is occupied.
// Reset: all pipelines and the queue empty, registers return to threshold
//   328, gain divisor 2, min speed 328.
module servo_velocity_step_unit import svs_pkg::*; #(
	parameter int POS_WIDTH   = POS_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	svs_in_if.sink            sample,
	svs_out_if.source         cmd,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	`include "servo_velocity_step_unit_assert.svh"

	localparam int ENT_W = 3 * (POS_WIDTH + 1) + 4;

	logic [THR_W-1:0]     thr_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [MS_W-1:0]      ms_q;
	logic [THR_SQ_W-1:0]  thr_sq_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	svs_cfg_t             cfg;

	logic                 q_push, q_pop;
	logic [ENT_W-1:0]     q_wdata, q_rdata;
	svs_q_stat_t          q_stat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	// register writes; squared threshold follows in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RST;
			gain_q   <= GAIN_RST;
			ms_q     <= MS_RST;
			thr_sq_q <= THR_SQ_RST;
		end else begin
			thr_sq_q <= THR_SQ_W'(thr_q) * THR_SQ_W'(thr_q);
			if (wr_en) begin
				case (reg_idx)
					REG_THR:  thr_q  <= pwdata[THR_W-1:0];
					REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
					REG_MS:   ms_q   <= pwdata[MS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_THR:  prdata = 32'(thr_q);
			REG_GAIN: prdata = 32'(gain_q);
			REG_MS:   prdata = 32'(ms_q);
			default:  prdata = '0;
		endcase
	end

	assign cfg.thr       = thr_q;
	assign cfg.thr_sq    = thr_sq_q;
	assign cfg.gain      = gain_q;
	assign cfg.spd_floor = ms_q;

	svs_front #(
		.POS_WIDTH (POS_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cfg    (cfg),
		.q_stat (q_stat),
		.push   (q_push),
		.entry  (q_wdata)
	);

	svs_queue #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	svs_back #(
		.POS_WIDTH (POS_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.entry  (q_rdata),
		.q_stat (q_stat),
		.pop    (q_pop),
		.cmd    (cmd)
	);

	// arrived words carry no velocity
	`SVS_ASSERT_IMPL(a_arrived_zero, cmd.valid && cmd.arrived, cmd.vel_x == '0 && cmd.vel_y == '0 && cmd.vel_z == '0)
	// queue is never pushed full or popped empty
	`SVS_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full)
	`SVS_ASSERT_IMPL(a_no_underflow, q_pop, !q_stat.empty)
	// front only backs up behind a full queue
	`SVS_ASSERT_IMPL(a_stall_full, !sample.ready, q_stat.full)
	// a push with no pop leaves a word behind
	`SVS_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !q_stat.empty)

endmodule

@@ sv/svs_front.sv @@
// Front end: position error, magnitudes, arrival check, push into queue.
module svs_front import svs_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	svs_in_if.sink                         sample,
	input  svs_cfg_t                       cfg,
	input  svs_q_stat_t                    q_stat,
	output logic                           push,
	output logic [3*(POS_WIDTH+1)+3:0]     entry
);

	localparam int MW = POS_WIDTH + 1;
	localparam int CW = (MW > THR_W) ? MW : THR_W;
	localparam int SUM_W = THR_SQ_W + 2;

	logic                 adv;
	logic signed [MW-1:0] tgt [3];
	logic signed [MW-1:0] cur [3];
	logic [MW-1:0]        a_c [3];
	logic [2:0]           neg_c;
	logic [2:0]           lt_c;
	logic [SUM_W-1:0]     sum_c;
	logic                 near_c;

	logic                 v_s1, v_s2, v_s3;
	logic signed [MW-1:0] d_s1 [3];
	logic [MW-1:0]        a_s2 [3];
	logic [MW-1:0]        a_s3 [3];
	logic [2:0]           neg_s2, neg_s3;
	logic                 lt_s2, lt_s3;
	logic [THR_SQ_W-1:0]  sq_s3 [3];

	// stall only when the last stage holds a word the queue cannot take
	assign adv          = !(v_s3 && q_stat.full);
	assign sample.ready = adv;
	assign push         = v_s3 && !q_stat.full;

	// sign-extended operands
	assign tgt[0] = {sample.target_x[POS_WIDTH-1], sample.target_x};
	assign tgt[1] = {sample.target_y[POS_WIDTH-1], sample.target_y};
	assign tgt[2] = {sample.target_z[POS_WIDTH-1], sample.target_z};
	assign cur[0] = {sample.current_x[POS_WIDTH-1], sample.current_x};
	assign cur[1] = {sample.current_y[POS_WIDTH-1], sample.current_y};
	assign cur[2] = {sample.current_z[POS_WIDTH-1], sample.current_z};

	// magnitude, per-axis threshold check, velocity signs
	// x and y velocity is the negated error, z keeps the error sign
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a_c[i]  = d_s1[i][MW-1] ? $unsigned(-d_s1[i]) : $unsigned(d_s1[i]);
			lt_c[i] = CW'(a_c[i]) < CW'(cfg.thr);
		end
		neg_c[0] = !d_s1[0][MW-1];
		neg_c[1] = !d_s1[1][MW-1];
		neg_c[2] = d_s1[2][MW-1] || (d_s1[2] == '0);
	end

	// squared length against squared threshold
	assign sum_c  = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
	assign near_c = lt_s3 && (sum_c < SUM_W'(cfg.thr_sq));
	assign entry  = {near_c, neg_s3, a_s3[2], a_s3[1], a_s3[0]};

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= tgt[i] - cur[i];
				a_s2[i]  <= a_c[i];
				a_s3[i]  <= a_s2[i];
				sq_s3[i] <= THR_SQ_W'(THR_W'(a_s2[i])) * THR_SQ_W'(THR_W'(a_s2[i]));
			end
			neg_s2 <= neg_c;
			neg_s3 <= neg_s2;
			lt_s2  <= &lt_c;
			lt_s3  <= lt_s2;
		end
	end

endmodule

@@ sv/svs_queue.sv @@
// Short queue between front and back.
module svs_queue import svs_pkg::*; #(
	parameter int WIDTH = 4,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output svs_q_stat_t      stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

@@ sv/svs_back.sv @@
// Back end: gain divide, min-speed scaling, saturation, output register.
module svs_back import svs_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  svs_cfg_t                   cfg,
	input  logic [3*(POS_WIDTH+1)+3:0] entry,
	input  svs_q_stat_t                q_stat,
	output logic                       pop,
	svs_out_if.source                  cmd
);

	localparam int MW    = POS_WIDTH + 1;
	localparam int ENT_W = 3 * MW + 4;
	localparam int NDS   = (MW + GDIG - 1) / GDIG;
	localparam int NUMW  = NDS * GDIG;
	localparam int SW    = MS_W;
	localparam int CW    = (MW > MS_W) ? MW : MS_W;
	localparam int PW    = ((MW > VEL_W) ? MW : VEL_W) + 1;

	// one radix-2^GDIG digit of a divide by a small gain
	function automatic logic [GDIG+GAIN_W-1:0] gain_digit(
		input logic [GAIN_W-1:0] rem,
		input logic [GDIG-1:0]   bits,
		input logic [GAIN_W-1:0] dvsr
	);
		logic [GAIN_W:0] r;
		logic [GDIG-1:0] q;
		r = {1'b0, rem};
		q = '0;
		for (int j = GDIG - 1; j >= 0; j--) begin
			r = {r[GAIN_W-1:0], bits[j]};
			if (r >= {1'b0, dvsr}) begin
				r    = r - {1'b0, dvsr};
				q[j] = 1'b1;
			end
		end
		return {q, r[GAIN_W-1:0]};
	endfunction

	// one restoring step of the scaling divide: {quotient bit, remainder}
	function automatic logic [SW:0] scale_step(
		input logic [SW-1:0] rem,
		input logic          bit_in,
		input logic [SW-1:0] dvsr
	);
		logic [SW:0] r;
		logic        q;
		r = {rem, bit_in};
		q = 1'b0;
		if (r >= {1'b0, dvsr}) begin
			r = r - {1'b0, dvsr};
			q = 1'b1;
		end
		return {q, r[SW-1:0]};
	endfunction

	// saturate a signed magnitude to the velocity range
	function automatic logic [VEL_W-1:0] pack_vel(input logic neg, input logic [PW-1:0] m);
		logic [VEL_W-1:0] v;
		if (neg) begin
			if (m > PW'(VEL_NEG_MAG))
				v = {1'b1, {(VEL_W - 1){1'b0}}};
			else
				v = -m[VEL_W-1:0];
		end else begin
			if (m > PW'(VEL_POS_MAG))
				v = {1'b0, {(VEL_W - 1){1'b1}}};
			else
				v = m[VEL_W-1:0];
		end
		return v;
	endfunction

	logic              adv;
	logic [GAIN_W-1:0] g_eff;
	logic              ent_near;
	logic [2:0]        ent_neg;

	// gain divider
	logic [NUMW-1:0]   gin_num [NDS][3];
	logic [GAIN_W-1:0] gin_rem [NDS][3];
	logic [NUMW-1:0]   gnx_num [NDS][3];
	logic [GAIN_W-1:0] gnx_rem [NDS][3];
	logic [NDS-1:0]    gdv_s;
	logic [NUMW-1:0]   gdn_s [NDS][3];
	logic [GAIN_W-1:0] gdr_s [NDS][3];
	logic [NDS-1:0]    gdnear_s;
	logic [2:0]        gdneg_s [NDS];

	// max and scale decision
	logic [MW-1:0]     m_c [3];
	logic [MW-1:0]     big_c;
	logic              scl_c;
	logic              v_mx;
	logic [MW-1:0]     m_mx [3];
	logic [SW-1:0]     big_mx;
	logic              scl_mx, near_mx;
	logic [2:0]        neg_mx;

	// scaling product
	logic              v_ml;
	logic [2*SW-1:0]   prod_ml [3];
	logic [MW-1:0]     m_ml [3];
	logic [SW-1:0]     big_ml;
	logic              scl_ml, near_ml;
	logic [2:0]        neg_ml;

	// scaling divider
	logic [SW-1:0]     sin_rem [SW][3];
	logic [SW-1:0]     sin_num [SW][3];
	logic [SW-1:0]     sin_dvsr [SW];
	logic [SW-1:0]     snx_rem [SW][3];
	logic [SW-1:0]     snx_num [SW][3];
	logic [SW-1:0]     sdv_s;
	logic [SW-1:0]     sdr_s [SW][3];
	logic [SW-1:0]     sdq_s [SW][3];
	logic [MW-1:0]     sdm_s [SW][3];
	logic [SW-1:0]     sdbig_s [SW];
	logic [SW-1:0]     sdscl_s, sdnear_s;
	logic [2:0]        sdneg_s [SW];

	// output register
	logic [PW-1:0]     mag_c [3];
	logic              out_valid_q;
	logic              arrived_q;
	logic [VEL_W-1:0]  vel_q [3];

	// whole back pipeline moves when the output slot frees up
	assign adv   = !out_valid_q || cmd.ready;
	assign pop   = adv && !q_stat.empty;
	assign g_eff = (cfg.gain == '0) ? GAIN_W'(1) : cfg.gain;

	assign ent_near = entry[ENT_W-1];
	assign ent_neg  = entry[ENT_W-2 -: 3];

	// gain divider stage inputs
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gin_num[0][i] = NUMW'(entry[i*MW +: MW]);
			gin_rem[0][i] = '0;
		end
		for (int k = 1; k < NDS; k++) begin
			for (int i = 0; i < 3; i++) begin
				gin_num[k][i] = gdn_s[k-1][i];
				gin_rem[k][i] = gdr_s[k-1][i];
			end
		end
	end

	// gain divider digit logic, quotient shifts in at the bottom
	always_comb begin : gdiv_comb
		logic [GDIG+GAIN_W-1:0] res;
		for (int k = 0; k < NDS; k++) begin
			for (int i = 0; i < 3; i++) begin
				res = gain_digit(gin_rem[k][i], gin_num[k][i][NUMW-1 -: GDIG], g_eff);
				gnx_num[k][i] = {gin_num[k][i][NUMW-GDIG-1:0], res[GDIG+GAIN_W-1:GAIN_W]};
				gnx_rem[k][i] = res[GAIN_W-1:0];
			end
		end
	end

	// largest magnitude and whether it is below min speed
	always_comb begin
		for (int i = 0; i < 3; i++)
			m_c[i] = gdn_s[NDS-1][i][MW-1:0];
		big_c = m_c[0];
		if (m_c[1] > big_c)
			big_c = m_c[1];
		if (m_c[2] > big_c)
			big_c = m_c[2];
		scl_c = (big_c != '0) && (CW'(big_c) < CW'(cfg.spd_floor));
	end

	// scaling divider stage inputs
	always_comb begin
		sin_dvsr[0] = big_ml;
		for (int i = 0; i < 3; i++) begin
			sin_rem[0][i] = prod_ml[i][2*SW-1:SW];
			sin_num[0][i] = prod_ml[i][SW-1:0];
		end
		for (int k = 1; k < SW; k++) begin
			sin_dvsr[k] = sdbig_s[k-1];
			for (int i = 0; i < 3; i++) begin
				sin_rem[k][i] = sdr_s[k-1][i];
				sin_num[k][i] = sdq_s[k-1][i];
			end
		end
	end

	// scaling divider steps, divisor is the largest magnitude
	always_comb begin : sdiv_comb
		logic [SW:0] res;
		for (int k = 0; k < SW; k++) begin
			for (int i = 0; i < 3; i++) begin
				res = scale_step(sin_rem[k][i], sin_num[k][i][SW-1], sin_dvsr[k]);
				snx_rem[k][i] = res[SW-1:0];
				snx_num[k][i] = {sin_num[k][i][SW-2:0], res[SW]};
			end
		end
	end

	// pick scaled or plain magnitude
	always_comb begin
		for (int i = 0; i < 3; i++)
			mag_c[i] = sdscl_s[SW-1] ? PW'(sdq_s[SW-1][i]) : PW'(sdm_s[SW-1][i]);
	end

	// valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gdv_s       <= '0;
			v_mx        <= 1'b0;
			v_ml        <= 1'b0;
			sdv_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			gdv_s       <= {gdv_s[NDS-2:0], !q_stat.empty};
			v_mx        <= gdv_s[NDS-1];
			v_ml        <= v_mx;
			sdv_s       <= {sdv_s[SW-2:0], v_ml};
			out_valid_q <= sdv_s[SW-1];
		end
	end

	// payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			// gain divider
			gdnear_s   <= {gdnear_s[NDS-2:0], ent_near};
			gdneg_s[0] <= ent_neg;
			for (int k = 1; k < NDS; k++)
				gdneg_s[k] <= gdneg_s[k-1];
			for (int k = 0; k < NDS; k++) begin
				for (int i = 0; i < 3; i++) begin
					gdn_s[k][i] <= gnx_num[k][i];
					gdr_s[k][i] <= gnx_rem[k][i];
				end
			end

			// max stage
			for (int i = 0; i < 3; i++)
				m_mx[i] <= m_c[i];
			big_mx  <= SW'(big_c);
			scl_mx  <= scl_c;
			near_mx <= gdnear_s[NDS-1];
			neg_mx  <= gdneg_s[NDS-1];

			// product stage
			for (int i = 0; i < 3; i++) begin
				prod_ml[i] <= (2*SW)'(SW'(m_mx[i])) * (2*SW)'(cfg.spd_floor);
				m_ml[i]    <= m_mx[i];
			end
			big_ml  <= big_mx;
			scl_ml  <= scl_mx;
			near_ml <= near_mx;
			neg_ml  <= neg_mx;

			// scaling divider
			sdscl_s    <= {sdscl_s[SW-2:0], scl_ml};
			sdnear_s   <= {sdnear_s[SW-2:0], near_ml};
			sdbig_s[0] <= big_ml;
			sdneg_s[0] <= neg_ml;
			for (int i = 0; i < 3; i++)
				sdm_s[0][i] <= m_ml[i];
			for (int k = 1; k < SW; k++) begin
				sdbig_s[k] <= sdbig_s[k-1];
				sdneg_s[k] <= sdneg_s[k-1];
				for (int i = 0; i < 3; i++)
					sdm_s[k][i] <= sdm_s[k-1][i];
			end
			for (int k = 0; k < SW; k++) begin
				for (int i = 0; i < 3; i++) begin
					sdr_s[k][i] <= snx_rem[k][i];
					sdq_s[k][i] <= snx_num[k][i];
				end
			end

			// output word, zero velocity once arrived
			arrived_q <= sdnear_s[SW-1];
			for (int i = 0; i < 3; i++)
				vel_q[i] <= sdnear_s[SW-1] ? '0 : pack_vel(sdneg_s[SW-1][i], mag_c[i]);
		end
	end

	assign cmd.valid   = out_valid_q;
	assign cmd.arrived = arrived_q;
	assign cmd.vel_x   = vel_q[0];
	assign cmd.vel_y   = vel_q[1];
	assign cmd.vel_z   = vel_q[2];

endmodule
